[rtl/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg
// Types, constants and microprogram of the clamped PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned ERR_W    = DATA_W + 1;
  localparam int unsigned DIFF_W   = ERR_W + 1;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned ACC_SH   = 16;
  localparam int unsigned DERIV_W  = DIFF_W + DATA_W;
  localparam int unsigned PROD_W   = DERIV_W + DATA_W + 1;
  localparam int unsigned SUM_W    = 52;
  localparam int unsigned OUT_SH   = 8;
  localparam int unsigned Y_W      = SUM_W - OUT_SH;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W   = 3;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_STEP_TIME  = 3'd3,
    REG_STEP_RATE  = 3'd4,
    REG_OUT_MAX    = 3'd5,
    REG_OUT_MIN    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] target;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     limited;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0]        prop_gain;
    logic [DATA_W-1:0]        integ_gain;
    logic [DATA_W-1:0]        deriv_gain;
    logic [DATA_W-1:0]        step_time;
    logic [DATA_W-1:0]        step_rate;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] out_min;
  } cfg_t;

  typedef enum logic [2:0] {
    MA_ERR_IN,
    MA_ERR,
    MA_DIFF,
    MA_INTEG,
    MA_DERIV
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_TIME,
    MB_RATE,
    MB_PROP,
    MB_INTEG,
    MB_DERIV
  } mul_b_e;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_LOAD,
    SUM_ADD
  } sum_op_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_IN,
    COND_OUT
  } cond_e;

  typedef struct packed {
    mul_a_e  mul_a;
    mul_b_e  mul_b;
    logic    err_en;
    logic    acc_en;
    logic    deriv_en;
    sum_op_e sum_op;
    logic    out_en;
  } ctrl_t;

  typedef struct packed {
    ctrl_t             ctrl;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_word(logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{ctrl: '{mul_a: MA_ERR_IN, mul_b: MB_TIME, err_en: 1'b0, acc_en: 1'b0,
                  deriv_en: 1'b0, sum_op: SUM_HOLD, out_en: 1'b0},
          cond: COND_IN, target: '0};
    unique case (step)
      3'd0: begin
        w.ctrl.err_en = 1'b1;
      end
      3'd1: begin
        w.ctrl.mul_a  = MA_ERR;
        w.ctrl.mul_b  = MB_PROP;
        w.ctrl.acc_en = 1'b1;
        w.cond        = COND_NEXT;
      end
      3'd2: begin
        w.ctrl.mul_a  = MA_DIFF;
        w.ctrl.mul_b  = MB_RATE;
        w.ctrl.sum_op = SUM_LOAD;
        w.cond        = COND_NEXT;
      end
      3'd3: begin
        w.ctrl.mul_a    = MA_INTEG;
        w.ctrl.mul_b    = MB_INTEG;
        w.ctrl.deriv_en = 1'b1;
        w.cond          = COND_NEXT;
      end
      3'd4: begin
        w.ctrl.mul_a  = MA_DERIV;
        w.ctrl.mul_b  = MB_DERIV;
        w.ctrl.sum_op = SUM_ADD;
        w.cond        = COND_NEXT;
      end
      3'd5: begin
        w.ctrl.sum_op = SUM_ADD;
        w.cond        = COND_NEXT;
      end
      3'd6: begin
        w.ctrl.out_en = 1'b1;
        w.cond        = COND_OUT;
        w.target      = 3'd0;
      end
      default: begin
        w.cond   = COND_OUT;
        w.target = 3'd0;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/pid_controller_clamped_core.sv]
// ----------------------------------------------------------------------------
// pid_controller_clamped_core
// Fixed-point PID controller with saturating integrator and output clamp.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one measured value
// and target per transfer; output channel (out_valid_o/out_ready_i/
// out_data_o) returns the clamped drive and the limited flag.
// Configuration channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i)
// writes gains, step time, step rate and clamps; it is always ready and
// writes with an index beyond the register list are dropped.
// A microprogram of seven steps runs one shared 34x17 multiplier for the
// four products and the integrator update, so a new input transfer is
// taken only after the previous item has run through every step; the
// result is loaded into the output register on the last step.
// The result waits in an output register, so the next input is taken while
// it is pending; if the receiver stalls, the sequencer holds on its last
// step until that register frees.
// Reset clears the integrator and the previous error and loads the
// register defaults; the block is ready for input right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped_core import pcc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  out_free;

  pcc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pcc_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  pcc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/pcc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pcc_cfg_regs
// Gain, timing and clamp registers written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_cfg_regs import pcc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PROP_GAIN:  cfg_d.prop_gain  = cfg_data_i;
        REG_INTEG_GAIN: cfg_d.integ_gain = cfg_data_i;
        REG_DERIV_GAIN: cfg_d.deriv_gain = cfg_data_i;
        REG_STEP_TIME:  cfg_d.step_time  = cfg_data_i;
        REG_STEP_RATE:  cfg_d.step_rate  = cfg_data_i;
        REG_OUT_MAX:    cfg_d.out_max    = $signed(cfg_data_i);
        REG_OUT_MIN:    cfg_d.out_min    = $signed(cfg_data_i);
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  <= 16'd256;
      cfg_q.integ_gain <= 16'd256;
      cfg_q.deriv_gain <= 16'd256;
      cfg_q.step_time  <= 16'd655;
      cfg_q.step_rate  <= 16'd100;
      cfg_q.out_max    <= 16'sh7FFF;
      cfg_q.out_min    <= 16'sh8000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pcc_sequencer.sv]
// ----------------------------------------------------------------------------
// pcc_sequencer
// Step counter over the microprogram ROM with wait-for-input and
// wait-for-output jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_sequencer import pcc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_free_i,
  output logic      in_ready_o,
  output ctrl_t     ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uword;
  logic              go;

  assign uword = ucode_word(step_q);

  always_comb begin
    unique case (uword.cond)
      COND_NEXT: go = 1'b1;
      COND_IN:   go = in_valid_i;
      COND_OUT:  go = out_free_i;
      default:   go = 1'b0;
    endcase

    in_ready_o = (uword.cond == COND_IN);

    step_d = step_q;
    if (go) begin
      if (uword.cond == COND_OUT) begin
        step_d = uword.target;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end

    ctrl_o = uword.ctrl;
    if (!go) begin
      ctrl_o.err_en   = 1'b0;
      ctrl_o.acc_en   = 1'b0;
      ctrl_o.deriv_en = 1'b0;
      ctrl_o.sum_op   = SUM_HOLD;
      ctrl_o.out_en   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pcc_datapath.sv]
// ----------------------------------------------------------------------------
// pcc_datapath
// Shared multiplier, saturating integrator, sum register, clamp and output
// register of the PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_datapath import pcc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_data_i,
  input  wire cfg_t cfg_i,
  input  wire ctrl_t ctrl_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic signed [ERR_W-1:0]   err_in;
  logic signed [ERR_W-1:0]   err_q, last_err_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W:0]     acc_sum;
  logic signed [DERIV_W-1:0] deriv_q;
  logic signed [DERIV_W-1:0] mul_a;
  logic signed [DATA_W:0]    mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic signed [Y_W-1:0]     y_raw, y_hi, y_lo;
  logic                      lim;
  logic                      out_valid_q;
  out_t                      out_q;

  assign err_in = ERR_W'(in_data_i.target) - ERR_W'(in_data_i.measured);

  always_comb begin
    unique case (ctrl_i.mul_a)
      MA_ERR_IN: mul_a = DERIV_W'(err_in);
      MA_ERR:    mul_a = DERIV_W'(err_q);
      MA_DIFF:   mul_a = DERIV_W'(diff_q);
      MA_INTEG:  mul_a = DERIV_W'($signed(acc_q[ACC_W-1:ACC_SH]));
      MA_DERIV:  mul_a = deriv_q;
      default:   mul_a = '0;
    endcase
    unique case (ctrl_i.mul_b)
      MB_TIME:  mul_b = $signed({1'b0, cfg_i.step_time});
      MB_RATE:  mul_b = $signed({1'b0, cfg_i.step_rate});
      MB_PROP:  mul_b = $signed({1'b0, cfg_i.prop_gain});
      MB_INTEG: mul_b = $signed({1'b0, cfg_i.integ_gain});
      MB_DERIV: mul_b = $signed({1'b0, cfg_i.deriv_gain});
      default:  mul_b = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_comb begin
    acc_sum = $signed({acc_q[ACC_W-1], acc_q}) + $signed(prod_q[ACC_W:0]);
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_d = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_d = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    unique case (ctrl_i.sum_op)
      SUM_LOAD: sum_d = SUM_W'(prod_q);
      SUM_ADD:  sum_d = sum_q + SUM_W'(prod_q);
      default:  sum_d = sum_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      last_err_q <= '0;
    end else begin
      if (ctrl_i.acc_en) begin
        acc_q <= acc_d;
      end
      if (ctrl_i.err_en) begin
        last_err_q <= err_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.err_en) begin
      err_q  <= err_in;
      diff_q <= DIFF_W'(err_in) - DIFF_W'(last_err_q);
    end
    if (ctrl_i.deriv_en) begin
      deriv_q <= prod_q[DERIV_W-1:0];
    end
    sum_q <= sum_d;
  end

  always_comb begin
    y_raw = sum_q[SUM_W-1:OUT_SH];
    lim   = 1'b0;
    y_hi  = y_raw;
    if (y_raw > Y_W'(cfg_i.out_max)) begin
      y_hi = Y_W'(cfg_i.out_max);
      lim  = 1'b1;
    end
    y_lo = y_hi;
    if (y_hi < Y_W'(cfg_i.out_min)) begin
      y_lo = Y_W'(cfg_i.out_min);
      lim  = 1'b1;
    end
  end

  assign out_free_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_en) begin
      out_q.drive   <= y_lo[DATA_W-1:0];
      out_q.limited <= lim;
    end
  end

endmodule

`default_nettype wire
